FILE: rtl/mrms_pkg.sv
// Package for the moving-window RMS level detector.
// Holds field widths, register indexes, reset values and the sequencer state type.
// No dependencies; every rtl file refers to it by scoped names.
package mrms_pkg;

  localparam int SAMPLE_W = 12;
  localparam int SQ_W     = 24;
  localparam int MEAN_W   = 24;
  localparam int ROOT_W   = 12;
  localparam int CFG_W    = 12;
  localparam int ADDR_W   = 1;

  localparam int WINDOW_LEN_DEFAULT = 64;

  // Root bits settled per cycle by the root unit.
  localparam int ROOT_BITS_PER_CYCLE = 2;

  localparam logic [ADDR_W-1:0] REG_CENTER_OFFSET = 1'b0;
  localparam logic [ADDR_W-1:0] REG_LEVEL_LIMIT   = 1'b1;

  localparam logic [CFG_W-1:0] CENTER_OFFSET_RESET = 12'd2048;
  localparam logic [CFG_W-1:0] LEVEL_LIMIT_RESET   = 12'd500;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_ROOT,
    ST_OUT
  } state_t;

endpackage

FILE: rtl/mrms_cell.sv
// One cell of the square window: holds one squared deviation.
// On a shift it takes its left neighbor's value. Depends on mrms_pkg.
module mrms_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       shift,
  input  logic [mrms_pkg::SQ_W-1:0]  d,
  output logic [mrms_pkg::SQ_W-1:0]  q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

FILE: rtl/mrms_div.sv
// Division of the window sum by the constant window length.
// Multiplies by a rounded-up reciprocal, with the dividend and the product each registered. Depends on mrms_pkg.
module mrms_div #(
  parameter int DIVISOR = mrms_pkg::WINDOW_LEN_DEFAULT,
  parameter int DVD_W   = 30
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [DVD_W-1:0]              dividend,
  output logic                          done,
  output logic [mrms_pkg::MEAN_W-1:0]   quotient
);

  // With SHIFT = DVD_W + clog2(DIVISOR) and MULT = ceil(2^SHIFT / DIVISOR), the
  // excess MULT * DIVISOR - 2^SHIFT stays below 2^(SHIFT - DVD_W), so the top bits
  // of dividend * MULT equal the floor quotient for every dividend of DVD_W bits.
  localparam int SHIFT  = DVD_W + $clog2(DIVISOR);
  localparam int MULT_W = DVD_W + 1;
  localparam int PROD_W = DVD_W + MULT_W;
  localparam longint unsigned SCALE  = 64'd1 << SHIFT;
  localparam longint unsigned MULT_L = (SCALE + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MULT_W-1:0] MULT = MULT_W'(MULT_L);

  // The dividend is registered first so the multiply works from a register of its own.
  logic [DVD_W-1:0]  dvd;
  logic [PROD_W-1:0] prod;
  logic              mul_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_en <= 1'b0;
      done   <= 1'b0;
    end else begin
      mul_en <= start;
      done   <= mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
    end
    if (mul_en) begin
      prod <= PROD_W'(dvd) * PROD_W'(MULT);
    end
  end

  assign quotient = prod[SHIFT +: mrms_pkg::MEAN_W];

endmodule

FILE: rtl/mrms_root.sv
// Iterative floor square root of the window mean, two radicand bits per root bit.
// Settles ROOT_BITS_PER_CYCLE root bits per cycle while busy. Depends on mrms_pkg.
module mrms_root (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mrms_pkg::MEAN_W-1:0]   radicand,
  output logic                          done,
  output logic [mrms_pkg::ROOT_W-1:0]   root
);

  localparam int MW    = mrms_pkg::MEAN_W;
  localparam int RTW   = mrms_pkg::ROOT_W;
  localparam int RW    = RTW + 2;
  localparam int PER   = mrms_pkg::ROOT_BITS_PER_CYCLE;
  localparam int STEPS = RTW / PER;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [MW-1:0]    rad;
  logic [MW-1:0]    rad_next;
  logic [RW-1:0]    rem;
  logic [RW-1:0]    rem_next;
  logic [RTW-1:0]   root_next;
  logic [RW+1:0]    wide;
  logic [RW+1:0]    trial;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  always_comb begin
    rad_next  = rad;
    rem_next  = rem;
    root_next = root;
    wide      = '0;
    trial     = '0;
    for (int k = 0; k < PER; k++) begin
      wide     = {rem_next, rad_next[MW-1:MW-2]};
      rad_next = {rad_next[MW-3:0], 2'b00};
      trial    = (RW + 2)'({root_next, 2'b01});
      if (wide >= trial) begin
        wide      = wide - trial;
        root_next = {root_next[RTW-2:0], 1'b1};
      end else begin
        root_next = {root_next[RTW-2:0], 1'b0};
      end
      rem_next = wide[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(STEPS);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad_next;
      rem  <= rem_next;
      root <= root_next;
    end
  end

endmodule

FILE: rtl/moving_rms_level_detector_core.sv
// Moving-window RMS level detector, top level.
// A request is accepted in ST_IDLE; the window and running sum are updated in ST_SUM,
// the mean comes from the reciprocal divider in ST_DIV and its root from the root unit
// in ST_ROOT, and ST_OUT loads the output register once it is free. The next request
// is taken only after that result has been loaded into the output register.
// Reset (rst, synchronous) zeroes every window cell and the running sum at once and
// restores center_offset to 2048 and level_limit to 500.
module moving_rms_level_detector_core #(
  parameter int WINDOW_LEN = mrms_pkg::WINDOW_LEN_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  // Input stream. s_tdata: [11:0] adc_sample, [15:12] zero.
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [15:0]                  s_tdata,
  // Output stream. m_tdata: [11:0] rms_level, [23:12] sample_echo.
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [23:0]                  m_tdata,
  // m_tuser: [0] loud.
  output logic [0:0]                   m_tuser,
  // Configuration writes.
  input  logic                         cfg_we,
  input  logic [mrms_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [mrms_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int SW    = mrms_pkg::SAMPLE_W;
  localparam int SQW   = mrms_pkg::SQ_W;
  localparam int RTW   = mrms_pkg::ROOT_W;
  // The sum of WINDOW_LEN squares of at most 24 bits each.
  localparam int SUM_W = SQW + $clog2(WINDOW_LEN);

  mrms_pkg::state_t state;
  mrms_pkg::state_t state_next;

  // Configuration registers.
  logic [mrms_pkg::CFG_W-1:0] center_offset;
  logic [mrms_pkg::CFG_W-1:0] level_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_offset <= mrms_pkg::CENTER_OFFSET_RESET;
      level_limit   <= mrms_pkg::LEVEL_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mrms_pkg::REG_CENTER_OFFSET: center_offset <= cfg_wdata;
        mrms_pkg::REG_LEVEL_LIMIT:   level_limit   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake and sequencing strobes.
  logic s_accept;
  logic shift_en;
  logic div_start;
  logic div_done;
  logic root_start;
  logic root_done;
  logic load_out;

  // The request's deviation is squared as it is accepted; the raw sample is
  // kept for the echo field.
  logic [SW-1:0]  sample;
  logic [SW-1:0]  mag;
  logic [SQW-1:0] sq;
  logic [SW-1:0]  echo;

  assign sample   = s_tdata[SW-1:0];
  assign mag      = (sample >= center_offset) ? (sample - center_offset)
                                              : (center_offset - sample);
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (s_accept) begin
      sq   <= SQW'(mag) * SQW'(mag);
      echo <= sample;
    end
  end

  // The window is a row of cells. Each new square enters at cell 0 and every
  // older square moves one cell on, so the last cell always holds the square
  // that leaves the window, exactly as the oldest entry of a ring would.
  logic [SQW-1:0] tap [WINDOW_LEN];

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    if (i == 0) begin : g_head
      mrms_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift_en),
        .d     (sq),
        .q     (tap[i])
      );
    end else begin : g_body
      mrms_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift_en),
        .d     (tap[i-1]),
        .q     (tap[i])
      );
    end
  end

  // Running sum of the window: drop the leaving square, add the new one.
  logic [SUM_W-1:0] window_sum;
  logic [SUM_W-1:0] window_sum_next;

  assign window_sum_next = window_sum - SUM_W'(tap[WINDOW_LEN-1]) + SUM_W'(sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum <= '0;
    end else if (shift_en) begin
      window_sum <= window_sum_next;
    end
  end

  // Mean over the window, then its floor square root.
  logic [mrms_pkg::MEAN_W-1:0] mean;
  logic [RTW-1:0]              root;

  mrms_div #(
    .DIVISOR (WINDOW_LEN),
    .DVD_W   (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (window_sum_next),
    .done     (div_done),
    .quotient (mean)
  );

  mrms_root u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (mean),
    .done     (root_done),
    .root     (root)
  );

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      mrms_pkg::ST_IDLE: if (s_accept) state_next = mrms_pkg::ST_SUM;
      mrms_pkg::ST_SUM:  state_next = mrms_pkg::ST_DIV;
      mrms_pkg::ST_DIV:  if (div_done) state_next = mrms_pkg::ST_ROOT;
      mrms_pkg::ST_ROOT: if (root_done) state_next = mrms_pkg::ST_OUT;
      mrms_pkg::ST_OUT:  if (load_out) state_next = mrms_pkg::ST_IDLE;
      default:           state_next = mrms_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs. A finished result waits only for the output register,
  // which is free once its previous result has been taken downstream.
  always_comb begin
    s_tready   = 1'b0;
    shift_en   = 1'b0;
    div_start  = 1'b0;
    root_start = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      mrms_pkg::ST_IDLE: s_tready = 1'b1;
      mrms_pkg::ST_SUM: begin
        shift_en  = 1'b1;
        div_start = 1'b1;
      end
      mrms_pkg::ST_DIV:  root_start = div_done;
      mrms_pkg::ST_ROOT: ;
      mrms_pkg::ST_OUT:  load_out = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrms_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register: holds one result so the next request can be taken while
  // this one waits for the downstream side.
  logic           out_valid;
  logic [RTW-1:0] out_level;
  logic           out_loud;
  logic [SW-1:0]  out_echo;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_level <= root;
      out_loud  <= (root > level_limit);
      out_echo  <= echo;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_echo, out_level};
  assign m_tuser  = out_loud;

endmodule

FILE: bench/moving_rms_level_detector_core_tb.sv
// Self-checking testbench for the moving-window RMS level detector core.
// Needs mrms_pkg, moving_rms_level_detector_core and its submodules from the rtl folder.
// Runs a table of directed samples and register writes, then random phases checked against a behavioral predictor.
`timescale 1ns / 100ps

module moving_rms_level_detector_core_tb;

  localparam int WIN_LEN        = mrms_pkg::WINDOW_LEN_DEFAULT;
  // Cycles with no request moving on either side before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  // Pause after the last owed result has come back, before the verdict is printed.
  localparam int SETTLE_CYCLES  = 40;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_ITEMS    = 80;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  // One row of the directed table: either a sample request or a register write.
  // When has_level is set the expected result is written into the row itself.
  typedef struct packed {
    row_kind_t                   kind;
    logic [mrms_pkg::ADDR_W-1:0] addr;
    logic [11:0]                 value;
    logic                        has_level;
    logic [11:0]                 rms;
    logic                        loud;
  } stim_row_t;

  typedef struct packed {
    logic [11:0] rms;
    logic        loud;
    logic [11:0] echo;
  } level_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [mrms_pkg::ADDR_W-1:0] cfg_addr = mrms_pkg::REG_CENTER_OFFSET;
  logic [mrms_pkg::CFG_W-1:0]  cfg_wdata = '0;

  moving_rms_level_detector_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Mirror of the block's window of squared deviations and its running total, kept
  // as a ring with its own pointer, together with the two configuration registers.
  logic [23:0] square_ring [WIN_LEN];
  logic [29:0] square_total;
  int          ring_pos;
  logic [11:0] offset_mirror;
  logic [11:0] limit_mirror;

  // Results still owed by the block, oldest first.
  level_result_t pending_levels [$];
  level_result_t head_level;
  level_result_t predicted;

  int send_idle_pct = 9;
  int recv_idle_pct = 71;
  int fails = 0;
  int idle_cycles = 0;

  stim_row_t directed_rows [0:20];

  // Floor square root by building the root one bit at a time from the top.
  function automatic logic [11:0] floor_root(input logic [23:0] value);
    logic [11:0] root;
    logic [11:0] trial;
    logic [23:0] trial_sq;
    root = '0;
    for (int b = 11; b >= 0; b--) begin
      trial = root | (12'd1 << b);
      trial_sq = trial * trial;
      if (trial_sq <= value) root = trial;
    end
    return root;
  endfunction

  // Folds one sample into the mirrored window and returns the level the block
  // must report for it. The window starts all zero, so during warm-up the mean
  // still counts the empty cells.
  function automatic level_result_t predict_level(input logic [11:0] sample);
    logic [11:0]   deviation;
    logic [23:0]   square;
    logic [23:0]   mean;
    level_result_t r;
    deviation = (sample >= offset_mirror) ? sample - offset_mirror : offset_mirror - sample;
    square = deviation * deviation;
    square_total = square_total - square_ring[ring_pos] + square;
    square_ring[ring_pos] = square;
    ring_pos = (ring_pos == WIN_LEN - 1) ? 0 : ring_pos + 1;
    mean = 24'(square_total / WIN_LEN);
    r.rms = floor_root(mean);
    r.loud = (r.rms > limit_mirror);
    r.echo = sample;
    return r;
  endfunction

  // Offers one sample request, with a random gap first, and returns the
  // predicted result once the block has taken it. Valid is only lowered when
  // a gap is taken, so it never drops and rises within one step.
  task automatic send_sample(input logic [11:0] sample, output level_result_t level);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, sample};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    level = predict_level(sample);
  endtask

  // Stops offering requests until every owed result has come back, then lets
  // the pipeline settle so that the block is idle.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mrms_pkg::ADDR_W-1:0] addr, input logic [11:0] value);
    cfg_addr  <= addr;
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == mrms_pkg::REG_CENTER_OFFSET) offset_mirror = value;
    else if (addr == mrms_pkg::REG_LEVEL_LIMIT) limit_mirror = value;
    @(posedge clk);
  endtask

  // Receiver side: random backpressure, result checking and the watchdog.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      idle_cycles = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_levels.size() == 0) begin
          $error("unexpected result: rms_level %0d loud %0d sample_echo %0d",
                 m_tdata[11:0], m_tuser[0], m_tdata[23:12]);
          fails++;
        end else begin
          head_level = pending_levels.pop_front();
          if (m_tdata[11:0] !== head_level.rms) begin
            $error("rms_level: expected %0d, actual %0d", head_level.rms, m_tdata[11:0]);
            fails++;
          end
          if (m_tuser[0] !== head_level.loud) begin
            $error("loud: expected %0d, actual %0d", head_level.loud, m_tuser[0]);
            fails++;
          end
          if (m_tdata[23:12] !== head_level.echo) begin
            $error("sample_echo: expected %0d, actual %0d", head_level.echo, m_tdata[23:12]);
            fails++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("moving_rms_level_detector_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [11:0] sample;
    int          style;
    int          near;
    logic [11:0] new_offset;
    logic [11:0] new_limit;

    // Directed rows. The first two results right after reset can be read off
    // directly: a sample at the center gives zero, and a full-scale low sample
    // gives 2048 squared over 64, whose root is 256.
    directed_rows = '{
      '{ROW_SAMPLE, mrms_pkg::REG_CENTER_OFFSET, 12'd2048, 1'b1, 12'd0,   1'b0},
      '{ROW_SAMPLE, mrms_pkg::REG_CENTER_OFFSET, 12'd0,    1'b1, 12'd256, 1'b0},
      '{ROW_SAMPLE, mrms_pkg::REG_CENTER_OFFSET, 12'd4095, 1'b0, 12'd0,   1'b0},
      '{ROW_SAMPLE, mrms_pkg::REG_CENTER_OFFSET, 12'd2047, 1'b0, 12'd0,   1'b0},
      '{ROW_SAMPLE, mrms_pkg::REG_CENTER_OFFSET, 12'd2049, 1'b0, 12'd0,   1'b0},
      '{ROW_SAMPLE, mrms_pkg::REG_CENTER_OFFSET, 12'hAAA,  1'b0, 12'd0,   1'b0},
      '{ROW_SAMPLE, mrms_pkg::REG_CENTER_OFFSET, 12'h555,  1'b0, 12'd0,   1'b0},
      '{ROW_WRITE,  mrms_pkg::REG_CENTER_OFFSET, 12'd0,    1'b0, 12'd0,   1'b0},
      '{ROW_WRITE,  mrms_pkg::REG_LEVEL_LIMIT,   12'd0,    1'b0, 12'd0,   1'b0},
      '{ROW_SAMPLE, mrms_pkg::REG_CENTER_OFFSET, 12'd0,    1'b0, 12'd0,   1'b0},
      '{ROW_SAMPLE, mrms_pkg::REG_CENTER_OFFSET, 12'd4095, 1'b0, 12'd0,   1'b0},
      '{ROW_SAMPLE, mrms_pkg::REG_CENTER_OFFSET, 12'd4095, 1'b0, 12'd0,   1'b0},
      '{ROW_WRITE,  mrms_pkg::REG_LEVEL_LIMIT,   12'd2048, 1'b0, 12'd0,   1'b0},
      '{ROW_WRITE,  mrms_pkg::REG_CENTER_OFFSET, 12'd4095, 1'b0, 12'd0,   1'b0},
      '{ROW_SAMPLE, mrms_pkg::REG_CENTER_OFFSET, 12'd0,    1'b0, 12'd0,   1'b0},
      '{ROW_SAMPLE, mrms_pkg::REG_CENTER_OFFSET, 12'd4095, 1'b0, 12'd0,   1'b0},
      '{ROW_SAMPLE, mrms_pkg::REG_CENTER_OFFSET, 12'd1,    1'b0, 12'd0,   1'b0},
      '{ROW_WRITE,  mrms_pkg::REG_CENTER_OFFSET, 12'd2048, 1'b0, 12'd0,   1'b0},
      '{ROW_WRITE,  mrms_pkg::REG_LEVEL_LIMIT,   12'd4095, 1'b0, 12'd0,   1'b0},
      '{ROW_SAMPLE, mrms_pkg::REG_CENTER_OFFSET, 12'd2048, 1'b0, 12'd0,   1'b0},
      '{ROW_SAMPLE, mrms_pkg::REG_CENTER_OFFSET, 12'd0,    1'b0, 12'd0,   1'b0}
    };

    // Predictor state after reset: empty window, registers at their reset codes.
    foreach (square_ring[i]) square_ring[i] = '0;
    square_total  = '0;
    ring_pos      = 0;
    offset_mirror = mrms_pkg::CENTER_OFFSET_RESET;
    limit_mirror  = mrms_pkg::LEVEL_LIMIT_RESET;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, run with the sender mostly busy and the receiver mostly stalled.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(directed_rows[i].addr, directed_rows[i].value);
      end else begin
        send_sample(directed_rows[i].value, predicted);
        if (directed_rows[i].has_level)
          pending_levels.push_back('{directed_rows[i].rms, directed_rows[i].loud,
                                     directed_rows[i].value});
        else
          pending_levels.push_back(predicted);
      end
    end

    // Random phases. Each one sets both registers, to their reset values, to extremes
    // or to random values, and the idling pattern moves from a stalled receiver to a
    // slow sender and finally to full rate.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 9;
        recv_idle_pct = 71;
      end else if (phase < 6) begin
        send_idle_pct = 71;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: begin new_offset = 12'd2048; new_limit = 12'd500;  end
        1: begin new_offset = 12'd0;    new_limit = 12'd0;    end
        2: begin new_offset = 12'd4095; new_limit = 12'd2048; end
        4: begin new_offset = 12'd0;    new_limit = 12'd2048; end
        6: begin new_offset = 12'd4095; new_limit = 12'd0;    end
        default: begin
          new_offset = 12'($urandom_range(4095));
          new_limit  = 12'($urandom_range(2048));
        end
      endcase
      wait_drained();
      write_reg(mrms_pkg::REG_CENTER_OFFSET, new_offset);
      write_reg(mrms_pkg::REG_LEVEL_LIMIT, new_limit);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Runs of one kind of signal, long enough to move the window mean:
        // white noise, samples near either rail, quiet input near the center,
        // and a sustained swing to the rail farthest from the center.
        if (k % 16 == 0) style = $urandom_range(3);
        // Once in the run the sender holds off until the block has drained.
        if (phase == 4 && k == PHASE_ITEMS / 2) wait_drained();
        case (style)
          0: sample = 12'($urandom_range(4095));
          1: sample = 12'($urandom_range(1) ? 4095 - $urandom_range(15) : $urandom_range(15));
          2: begin
            near = int'(offset_mirror) + int'($urandom_range(64)) - 32;
            if (near < 0) near = 0;
            if (near > 4095) near = 4095;
            sample = 12'(near);
          end
          default: sample = 12'((offset_mirror >= 12'd2048) ? $urandom_range(7)
                                                            : 4095 - $urandom_range(7));
        endcase
        send_sample(sample, predicted);
        pending_levels.push_back(predicted);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("moving_rms_level_detector_core verification clean");
    end else begin
      $display("moving_rms_level_detector_core verification failed");
    end
    $finish;
  end

endmodule

FILE: moving_rms_level_detector_core.f
rtl/mrms_pkg.sv
rtl/mrms_cell.sv
rtl/mrms_div.sv
rtl/mrms_root.sv
rtl/moving_rms_level_detector_core.sv
bench/moving_rms_level_detector_core_tb.sv
